### rtl/core/address_value_lookup_cache_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the address and value lookup cache
// Concurrent assertion wrappers that compile away when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef ADDRESS_VALUE_LOOKUP_CACHE_ASSERT_SVH
`define ADDRESS_VALUE_LOOKUP_CACHE_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked at every rising edge outside reset.
`define AVLC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("avlc assertion failed");
// Next-cycle implication, checked at every rising edge outside reset.
`define AVLC_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("avlc assertion failed");
`else
`define AVLC_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define AVLC_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif

`endif

### rtl/core/avlc_pkg.sv
// ----------------------------------------------------------------------------
// avlc_pkg
// Shared widths, request codes and state type of the lookup cache.
// ----------------------------------------------------------------------------
package avlc_pkg;

    localparam int ENTRIES_DEF = 16;
    localparam int KEY_W       = 16;
    localparam int DATA_W      = 16;

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } t_state;

endpackage

### rtl/core/avlc_ram.sv
// ----------------------------------------------------------------------------
// avlc_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module avlc_ram #(
    parameter int DEPTH  = avlc_pkg::ENTRIES_DEF,
    parameter int ADDR_W = 4,
    parameter int WIDTH  = avlc_pkg::KEY_W + avlc_pkg::DATA_W
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/address_value_lookup_cache.sv
// ----------------------------------------------------------------------------
// address_value_lookup_cache
// Fill-only, fully associative table of address and value pairs.
// ----------------------------------------------------------------------------
// Operation: an accepted request starts a scan that reads the filled entries in
// order from index 0 and ends on the first key match or after the last filled
// entry; the result is valid the cycle after the scan ends.
// Throughput: one request per scan, set by the single read port of the table
// memory, which yields one key per cycle while the result register is free.
// Reset: synchronous, active low; empties the table and drops any pending result.
// ----------------------------------------------------------------------------
`include "address_value_lookup_cache_assert.svh"

module address_value_lookup_cache #(
    parameter int ENTRIES = avlc_pkg::ENTRIES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    // Request channel.
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic                       i_op,
    input  logic [avlc_pkg::KEY_W-1:0]  i_address,
    input  logic [avlc_pkg::DATA_W-1:0] i_write_value,
    // Result channel.
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic                       o_hit,
    output logic [avlc_pkg::DATA_W-1:0] o_read_value,
    output logic                       o_stored
);

    // Index width covers the table; the count width also holds ENTRIES itself.
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);
    localparam int WORD_W = avlc_pkg::KEY_W + avlc_pkg::DATA_W;
    localparam logic [CNT_W-1:0] ENT_CNT = CNT_W'(ENTRIES);

    // Control state.
    avlc_pkg::t_state r_state, n_state;
    logic [CNT_W-1:0] r_fill, n_fill;
    logic [CNT_W-1:0] r_idx, n_idx;
    logic             r_rd_vld, n_rd_vld;
    logic             r_out_vld, n_out_vld;

    // Captured request and the index of the read in flight.
    logic                        r_op, n_op;
    logic [avlc_pkg::KEY_W-1:0]  r_addr, n_addr;
    logic [avlc_pkg::DATA_W-1:0] r_wval, n_wval;
    logic [IDX_W-1:0]            r_rd_idx, n_rd_idx;

    // Result register, which parts the scan from the result channel.
    logic                        r_hit, n_hit;
    logic [avlc_pkg::DATA_W-1:0] r_rval, n_rval;
    logic                        r_stored, n_stored;

    // Table memory port signals.
    logic              ram_we;
    logic [IDX_W-1:0]  ram_waddr;
    logic [WORD_W-1:0] ram_wdata;
    logic              ram_re;
    logic [IDX_W-1:0]  ram_raddr;
    logic [WORD_W-1:0] ram_rdata;

    logic                        accept;
    logic                        out_free;
    logic                        scan_go;
    logic                        match;
    logic                        more;
    logic                        room;
    logic                        finish;
    logic [avlc_pkg::KEY_W-1:0]  rd_key;
    logic [avlc_pkg::DATA_W-1:0] rd_data;

    // Each table word holds the key in its upper half and the value below it,
    // so a single read returns both and a write always rewrites the pair.
    avlc_ram #(
        .DEPTH  (ENTRIES),
        .ADDR_W (IDX_W),
        .WIDTH  (WORD_W)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rd_key  = ram_rdata[WORD_W-1:avlc_pkg::DATA_W];
    assign rd_data = ram_rdata[avlc_pkg::DATA_W-1:0];

    // A new request is taken whenever no scan is running, even while the
    // previous result still waits in the result register.
    assign o_in_ready = (r_state == avlc_pkg::ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    // The scan only advances when the result register can take a result.
    // When it stalls, no read is issued, so the memory output holds too.
    assign out_free = !r_out_vld || i_out_ready;
    assign scan_go  = (r_state == avlc_pkg::ST_SCAN) && out_free;

    // The scan is pipelined: the key read in the previous cycle is compared
    // while the next index is read. Only indices below the fill count are
    // ever read, so unwritten entries never reach the compare.
    assign match  = r_rd_vld && (rd_key == r_addr);
    assign more   = (r_idx < r_fill);
    assign room   = (r_fill < ENT_CNT);
    assign finish = scan_go && (match || !more);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            avlc_pkg::ST_IDLE: begin
                if (accept) begin
                    n_state = avlc_pkg::ST_SCAN;
                end
            end
            avlc_pkg::ST_SCAN: begin
                if (finish) begin
                    n_state = avlc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = avlc_pkg::ST_IDLE;
            end
        endcase
    end

    // Scan datapath, memory controls and result.
    always_comb begin
        n_fill    = r_fill;
        n_idx     = r_idx;
        n_rd_vld  = r_rd_vld;
        n_op      = r_op;
        n_addr    = r_addr;
        n_wval    = r_wval;
        n_rd_idx  = r_rd_idx;
        n_hit     = r_hit;
        n_rval    = r_rval;
        n_stored  = r_stored;
        ram_we    = 1'b0;
        ram_waddr = r_rd_idx;
        ram_wdata = {r_addr, r_wval};
        ram_re    = 1'b0;
        ram_raddr = r_idx[IDX_W-1:0];

        if (accept) begin
            n_op     = i_op;
            n_addr   = i_address;
            n_wval   = i_write_value;
            n_idx    = '0;
            n_rd_vld = 1'b0;
        end

        if (scan_go) begin
            if (match) begin
                // First match from index 0: read it out or overwrite its value.
                n_hit = 1'b1;
                if (r_op == avlc_pkg::OP_WRITE) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_rd_idx;
                    n_rval    = '0;
                    n_stored  = 1'b1;
                end else begin
                    n_rval   = rd_data;
                    n_stored = 1'b0;
                end
            end else if (more) begin
                ram_re   = 1'b1;
                n_rd_idx = r_idx[IDX_W-1:0];
                n_rd_vld = 1'b1;
                n_idx    = r_idx + CNT_W'(1);
            end else begin
                // Miss over all filled entries: a write appends while room remains.
                n_hit  = 1'b0;
                n_rval = '0;
                if ((r_op == avlc_pkg::OP_WRITE) && room) begin
                    ram_we    = 1'b1;
                    ram_waddr = r_fill[IDX_W-1:0];
                    n_fill    = r_fill + CNT_W'(1);
                    n_stored  = 1'b1;
                end else begin
                    n_stored = 1'b0;
                end
            end
        end

        if (finish) begin
            n_out_vld = 1'b1;
        end else if (i_out_ready) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= avlc_pkg::ST_IDLE;
            r_fill    <= '0;
            r_idx     <= '0;
            r_rd_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_fill    <= n_fill;
            r_idx     <= n_idx;
            r_rd_vld  <= n_rd_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_op     <= n_op;
        r_addr   <= n_addr;
        r_wval   <= n_wval;
        r_rd_idx <= n_rd_idx;
        r_hit    <= n_hit;
        r_rval   <= n_rval;
        r_stored <= n_stored;
    end

    assign o_out_valid  = r_out_vld;
    assign o_hit        = r_hit;
    assign o_read_value = r_rval;
    assign o_stored     = r_stored;

    // The fill count never passes the table depth.
    `AVLC_ASSERT_IMP(a_fill_bound, i_clk, i_rst_n, 1'b1, r_fill <= ENT_CNT)
    // A table write is the last step of a scan and always yields a result.
    `AVLC_ASSERT_NXT(a_write_ends_scan, i_clk, i_rst_n, ram_we,
        o_out_valid && o_stored && (r_state == avlc_pkg::ST_IDLE))
    // A nonzero read value only comes from a lookup hit.
    `AVLC_ASSERT_IMP(a_rval_on_hit, i_clk, i_rst_n, o_out_valid && (o_read_value != '0),
        o_hit && !o_stored)

endmodule

### tb/address_value_lookup_cache_checker.sv
// ----------------------------------------------------------------------------
// Lookup cache response checker
// Watches both channels of the lookup cache, predicts every response from
// its own copy of the table and compares the responses in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module address_value_lookup_cache_checker #(
    parameter int ENTRIES = avlc_pkg::ENTRIES_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    input  logic                        i_in_ready,
    input  logic                        i_op,
    input  logic [avlc_pkg::KEY_W-1:0]  i_address,
    input  logic [avlc_pkg::DATA_W-1:0] i_write_value,
    input  logic                        i_out_valid,
    input  logic                        i_out_ready,
    input  logic                        i_hit,
    input  logic [avlc_pkg::DATA_W-1:0] i_read_value,
    input  logic                        i_stored,
    output int                          o_pending_count,
    output int                          o_mismatch_count
);

    typedef struct packed {
        logic                        hit;
        logic [avlc_pkg::DATA_W-1:0] read_value;
        logic                        stored;
    } t_cache_response;

    logic [avlc_pkg::KEY_W-1:0]  cached_address [ENTRIES];
    logic [avlc_pkg::DATA_W-1:0] cached_value   [ENTRIES];
    int                          filled_entries;
    t_cache_response             predicted_responses [$];
    int                          mismatches;

    // Applies one request to the shadow table and returns the response it causes.
    function automatic t_cache_response predict_cache_access(
        input logic                        op,
        input logic [avlc_pkg::KEY_W-1:0]  address,
        input logic [avlc_pkg::DATA_W-1:0] write_value
    );
        t_cache_response response;
        int              match_index;
        response    = '0;
        match_index = -1;
        for (int i = 0; i < filled_entries; i++) begin
            if (match_index < 0 && cached_address[i] == address) begin
                match_index = i;
            end
        end
        if (op == avlc_pkg::OP_LOOKUP) begin
            if (match_index >= 0) begin
                response.hit        = 1'b1;
                response.read_value = cached_value[match_index];
            end
        end else if (match_index >= 0) begin
            cached_value[match_index] = write_value;
            response.hit              = 1'b1;
            response.stored           = 1'b1;
        end else if (filled_entries < ENTRIES) begin
            cached_address[filled_entries] = address;
            cached_value[filled_entries]   = write_value;
            filled_entries++;
            response.stored = 1'b1;
        end
        return response;
    endfunction

    always @(posedge i_clk) begin
        t_cache_response oldest;
        if (!i_rst_n) begin
            predicted_responses.delete();
            filled_entries = 0;
            mismatches     = 0;
        end else begin
            if (i_out_valid && i_out_ready) begin
                if (predicted_responses.size() == 0) begin
                    $error("unexpected response: hit %0d, read_value 0x%04h, stored %0d",
                           i_hit, i_read_value, i_stored);
                    mismatches++;
                end else begin
                    oldest = predicted_responses.pop_front();
                    if (i_hit !== oldest.hit) begin
                        $error("hit: expected %0d, actual %0d", oldest.hit, i_hit);
                        mismatches++;
                    end
                    if (i_read_value !== oldest.read_value) begin
                        $error("read_value: expected 0x%04h, actual 0x%04h",
                               oldest.read_value, i_read_value);
                        mismatches++;
                    end
                    if (i_stored !== oldest.stored) begin
                        $error("stored: expected %0d, actual %0d", oldest.stored, i_stored);
                        mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                predicted_responses.push_back(predict_cache_access(i_op, i_address,
                                                                   i_write_value));
            end
        end
        o_pending_count  <= predicted_responses.size();
        o_mismatch_count <= mismatches;
    end

endmodule

### tb/address_value_lookup_cache_test.sv
// ----------------------------------------------------------------------------
// Lookup cache testbench
// Drives lookups and writes into the fill-only lookup cache, first a directed
// walk through filling, updating and overflowing the table, then random
// traffic biased toward addresses held in the table. Both channels idle at
// random; a separate checker predicts and compares every response.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module address_value_lookup_cache_test;

    // Number of random requests after the directed part.
    localparam int RANDOM_REQUESTS  = 2000;
    // Length of the forced receiver hold-off. It is far longer than one scan,
    // so the block finishes its request, holds the response, takes one more request
    // whose scan then stalls, and refuses new requests while the sender keeps offering.
    localparam int LONG_HOLD_CYCLES = 250;
    // Cycles without any handshake before the run is declared hung. The worst
    // correct case is the long hold-off plus a full scan plus a sender gap.
    localparam int WATCHDOG_LIMIT   = 2000;
    // Settling time after the last expected response, so that a stray response is still caught.
    localparam int DRAIN_CYCLES     = 2 * avlc_pkg::ENTRIES_DEF + 4;

    typedef enum {
        SINK_ALWAYS,
        SINK_RANDOM,
        SINK_SLOW,
        SINK_HOLD
    } t_sink_mode;

    logic                        i_clk;
    logic                        i_rst_n;
    logic                        i_in_valid;
    logic                        o_in_ready;
    logic                        i_op;
    logic [avlc_pkg::KEY_W-1:0]  i_address;
    logic [avlc_pkg::DATA_W-1:0] i_write_value;
    logic                        o_out_valid;
    logic                        i_out_ready;
    logic                        o_hit;
    logic [avlc_pkg::DATA_W-1:0] o_read_value;
    logic                        o_stored;

    int                          pending_responses;
    int                          mismatch_count;

    // Addresses the stimulus has written; random requests draw most of their
    // addresses from here so that lookups and writes actually hit.
    logic [avlc_pkg::KEY_W-1:0]  written_addresses [$];
    // Requests left in the current sender burst.
    int                          burst_remaining;

    address_value_lookup_cache #(
        .ENTRIES(avlc_pkg::ENTRIES_DEF)
    ) i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_op         (i_op),
        .i_address    (i_address),
        .i_write_value(i_write_value),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_hit        (o_hit),
        .o_read_value (o_read_value),
        .o_stored     (o_stored)
    );

    address_value_lookup_cache_checker #(
        .ENTRIES(avlc_pkg::ENTRIES_DEF)
    ) lookup_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_ready      (o_in_ready),
        .i_op            (i_op),
        .i_address       (i_address),
        .i_write_value   (i_write_value),
        .i_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .i_hit           (o_hit),
        .i_read_value    (o_read_value),
        .i_stored        (o_stored),
        .o_pending_count (pending_responses),
        .o_mismatch_count(mismatch_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Presents one request at the falling edge and holds it until the block
    // takes it at a rising edge. Valid stays high on return, so back-to-back
    // requests never drop valid in between.
    task automatic offer_request(
        input logic                        op,
        input logic [avlc_pkg::KEY_W-1:0]  address,
        input logic [avlc_pkg::DATA_W-1:0] write_value
    );
        @(negedge i_clk);
        i_in_valid    <= 1'b1;
        i_op          <= op;
        i_address     <= address;
        i_write_value <= write_value;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Sends one request as part of a burst. When a burst runs out, the sender
    // goes quiet for a random gap (often none) and starts a new burst of
    // random length.
    task automatic send_in_bursts(
        input logic                        op,
        input logic [avlc_pkg::KEY_W-1:0]  address,
        input logic [avlc_pkg::DATA_W-1:0] write_value
    );
        int gap;
        if (burst_remaining == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid <= 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
            burst_remaining = $urandom_range(1, 24);
        end
        burst_remaining--;
        offer_request(op, address, write_value);
    endtask

    // Receiver: runs in phases, each with its own stall pattern. The fourth
    // phase is always the long hold-off, and it recurs now and then later.
    initial begin : response_sink
        t_sink_mode mode;
        int         phase;
        int         span;
        i_out_ready = 1'b0;
        phase       = 0;
        @(posedge i_rst_n);
        forever begin
            if (phase == 3 || $urandom_range(0, 29) == 0) begin
                mode = SINK_HOLD;
            end else begin
                mode = t_sink_mode'($urandom_range(0, 2));
            end
            span = (mode == SINK_HOLD) ? LONG_HOLD_CYCLES : $urandom_range(20, 80);
            repeat (span) begin
                @(negedge i_clk);
                case (mode)
                    SINK_ALWAYS: i_out_ready <= 1'b1;
                    SINK_RANDOM: i_out_ready <= 1'($urandom_range(0, 1));
                    SINK_SLOW:   i_out_ready <= ($urandom_range(0, 4) == 0);
                    default:     i_out_ready <= 1'b0;
                endcase
            end
            phase++;
        end
    end

    // Watchdog: a run that goes too long without any handshake on either
    // channel has hung, and fails.
    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("RESULT: ERROR");
        $finish;
    end

    initial begin : stimulus
        logic [avlc_pkg::KEY_W-1:0]  fill_address;
        logic [avlc_pkg::KEY_W-1:0]  last_address;
        logic [avlc_pkg::KEY_W-1:0]  address;
        logic [avlc_pkg::DATA_W-1:0] value;
        logic                        op;

        i_rst_n         = 1'b0;
        i_in_valid      = 1'b0;
        i_op            = avlc_pkg::OP_LOOKUP;
        i_address       = '0;
        i_write_value   = '0;
        burst_remaining = 0;
        last_address    = '0;
        repeat (5) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. A lookup in the empty table misses, and its write
        // value must be ignored.
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'h0000, 16'hFFFF);
        // First append, with the lowest address and the highest value.
        send_in_bursts(avlc_pkg::OP_WRITE, 16'h0000, 16'hFFFF);
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'h0000, 16'h0000);
        // Second append, with the highest address and the lowest value.
        send_in_bursts(avlc_pkg::OP_WRITE, 16'hFFFF, 16'h0000);
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'hFFFF, 16'hA5A5);
        // A write to an address already held updates it in place.
        send_in_bursts(avlc_pkg::OP_WRITE, 16'h0000, 16'h5A5A);
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'h0000, 16'h0000);
        // A lookup miss while the table is only partly filled.
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'h8001, 16'h0000);
        written_addresses.push_back(16'h0000);
        written_addresses.push_back(16'hFFFF);

        // Fill the rest of the table with distinct addresses.
        for (int i = 2; i < avlc_pkg::ENTRIES_DEF; i++) begin
            fill_address = 16'(i * 16'h0F0F);
            send_in_bursts(avlc_pkg::OP_WRITE, fill_address, 16'($urandom));
            written_addresses.push_back(fill_address);
            last_address = fill_address;
        end

        // With the table full a new address is dropped and stays unknown,
        // while the deepest entry can still be updated and read back.
        send_in_bursts(avlc_pkg::OP_WRITE, 16'h7FFE, 16'h1234);
        send_in_bursts(avlc_pkg::OP_LOOKUP, 16'h7FFE, 16'h0000);
        send_in_bursts(avlc_pkg::OP_WRITE, last_address, 16'hFFFF);
        send_in_bursts(avlc_pkg::OP_LOOKUP, last_address, 16'h0000);
        written_addresses.push_back(16'h7FFE);

        // Random part: mostly addresses that were written, some differing
        // from one in a single bit, the rest fully random.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            op = ($urandom_range(0, 1) == 0) ? avlc_pkg::OP_LOOKUP : avlc_pkg::OP_WRITE;
            address = written_addresses[$urandom_range(0, written_addresses.size() - 1)];
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4, 5: ;
                6, 7:    address = address ^ (16'h0001 << $urandom_range(0, avlc_pkg::KEY_W - 1));
                default: address = 16'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0) begin
                value = ($urandom_range(0, 1) == 0) ? 16'h0000 : 16'hFFFF;
            end else begin
                value = 16'($urandom);
            end
            send_in_bursts(op, address, value);
        end

        @(negedge i_clk);
        i_in_valid <= 1'b0;

        // Wait for every predicted response, then a little longer so that a
        // stray extra response would still be caught.
        do @(posedge i_clk); while (pending_responses != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

### address_value_lookup_cache.f
+incdir+rtl/core
rtl/core/avlc_pkg.sv
rtl/core/avlc_ram.sv
rtl/core/address_value_lookup_cache.sv
tb/address_value_lookup_cache_checker.sv
tb/address_value_lookup_cache_test.sv
